[rtl/core/rsa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared widths, register map, reset values and operation codes for the
// RSA character codec.
// ----------------------------------------------------------------------------
package rsa_pkg;

  localparam int VALUE_W        = 16;
  localparam int EXP_W          = 16;
  localparam int CHAR_W         = 8;
  localparam int CODE_WIDTH_DEF = 16;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_ENC_EXP = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DEC_EXP = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MODULUS = 2'd2;

  localparam logic [EXP_W-1:0]   ENC_EXP_RST = 16'd17;
  localparam logic [EXP_W-1:0]   DEC_EXP_RST = 16'd2753;
  localparam logic [VALUE_W-1:0] MODULUS_RST = 16'd3233;

  localparam logic REQ_ENCRYPT = 1'b0;
  localparam logic REQ_DECRYPT = 1'b1;

  typedef logic [1:0] op_t;
  localparam op_t OP_RED = 2'd0;
  localparam op_t OP_MUL = 2'd1;
  localparam op_t OP_SQR = 2'd2;

endpackage

[rtl/core/rsa_modmul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_modmul
// Bit-serial interleaved modular multiplier: res = a * b mod m, one bit of a
// per cycle, MSB first. Requires m nonzero and b no larger than m.
// ----------------------------------------------------------------------------
module rsa_modmul #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] m,
  output logic         done,
  output logic [W-1:0] res
);

  localparam int CNT_W = $clog2(W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]     a_r, a_nxt;
  logic [W-1:0]     b_r, b_nxt;
  logic [W-1:0]     m_r, m_nxt;
  logic [W-1:0]     acc_r, acc_nxt;

  logic [W:0] dbl;
  logic [W:0] dbl_red;
  logic [W:0] sum;
  logic [W:0] sum_red;
  logic [W:0] m_ext;

  always_comb begin
    m_ext   = {1'b0, m_r};
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
    sum     = dbl_red + (a_r[W-1] ? {1'b0, b_r} : '0);
    sum_red = (sum >= m_ext) ? (sum - m_ext) : sum;
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    m_nxt    = m_r;
    acc_nxt  = acc_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(W - 1);
      a_nxt    = a;
      b_nxt    = b;
      m_nxt    = m;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = sum_red[W-1:0];
      a_nxt   = a_r << 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    m_r   <= m_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign res  = acc_r;

endmodule

[rtl/core/rsa_char_codec.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_char_codec
// Textbook RSA encrypt/decrypt of one code per item by right-to-left
// square-and-multiply on a shared bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// One item is handled at a time. The base is first reduced by the modulus,
// then each exponent bit costs a square and, for a set bit, a multiply; every
// one of these runs on the single bit-serial multiplier, whose width W is the
// smaller of CODE_WIDTH and 16. A 16-bit exponent therefore takes up to 32
// multiplier passes; a zero exponent or a zero modulus skips the multiplier.
// A finished result waits in the output register while the next item is
// accepted.
module rsa_char_codec
  import rsa_pkg::*;
#(
  parameter int CODE_WIDTH = CODE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_req_type,
  input  logic [VALUE_W-1:0]    in_value,
  input  logic                  in_last_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VALUE_W-1:0]    out_result,
  output logic                  out_last_out,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CW = (CODE_WIDTH < VALUE_W) ? CODE_WIDTH : VALUE_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [EXP_W-1:0]   enc_exp_r, enc_exp_nxt;
  logic [EXP_W-1:0]   dec_exp_r, dec_exp_nxt;
  logic [VALUE_W-1:0] modulus_r, modulus_nxt;

  logic [1:0]         state_r, state_nxt;
  logic               go_r, go_nxt;
  op_t                op_r, op_nxt;
  logic               req_r, req_nxt;
  logic               last_r, last_nxt;
  logic [EXP_W-1:0]   exp_r, exp_nxt;
  logic [CW-1:0]      val_r, val_nxt;
  logic [CW-1:0]      base_r, base_nxt;
  logic [CW-1:0]      acc_r, acc_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] result_r, result_nxt;
  logic               last_out_r, last_out_nxt;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;
  logic [CW-1:0]        mod_m;
  logic [EXP_W-1:0]     in_exp;
  logic [CW-1:0]        mm_a;
  logic [CW-1:0]        mm_b;
  logic                 mm_done;
  logic [CW-1:0]        mm_res;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign mod_m   = modulus_r[CW-1:0];

  always_comb begin
    enc_exp_nxt = enc_exp_r;
    dec_exp_nxt = dec_exp_r;
    modulus_nxt = modulus_r;
    if (cfg_wr) begin
      case (reg_idx)
        REG_ENC_EXP: enc_exp_nxt = pwdata[EXP_W-1:0];
        REG_DEC_EXP: dec_exp_nxt = pwdata[EXP_W-1:0];
        REG_MODULUS: modulus_nxt = pwdata[VALUE_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ENC_EXP: prdata = APB_DATA_W'(enc_exp_r);
      REG_DEC_EXP: prdata = APB_DATA_W'(dec_exp_r);
      REG_MODULUS: prdata = APB_DATA_W'(modulus_r);
      default:     prdata = '0;
    endcase
  end

  always_comb begin
    case (op_r)
      OP_RED: begin
        mm_a = val_r;
        mm_b = CW'(1);
      end
      OP_MUL: begin
        mm_a = acc_r;
        mm_b = base_r;
      end
      default: begin
        mm_a = base_r;
        mm_b = base_r;
      end
    endcase
  end

  assign in_exp = (in_req_type == REQ_DECRYPT) ? dec_exp_r : enc_exp_r;

  always_comb begin
    state_nxt     = state_r;
    go_nxt        = 1'b0;
    op_nxt        = op_r;
    req_nxt       = req_r;
    last_nxt      = last_r;
    exp_nxt       = exp_r;
    val_nxt       = val_r;
    base_nxt      = base_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    result_nxt    = result_r;
    last_out_nxt  = last_out_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt  = in_req_type;
          last_nxt = in_last_in;
          val_nxt  = in_value[CW-1:0];
          exp_nxt  = in_exp;
          if (mod_m == '0) begin
            acc_nxt   = '0;
            state_nxt = S_DONE;
          end else if (in_exp == '0) begin
            acc_nxt   = CW'(1);
            state_nxt = S_DONE;
          end else begin
            acc_nxt   = CW'(1);
            op_nxt    = OP_RED;
            go_nxt    = 1'b1;
            state_nxt = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (mm_done) begin
          case (op_r)
            OP_RED: begin
              base_nxt = mm_res;
              op_nxt   = exp_r[0] ? OP_MUL : OP_SQR;
              go_nxt   = 1'b1;
            end
            OP_MUL: begin
              acc_nxt = mm_res;
              if (exp_r[EXP_W-1:1] == '0) begin
                state_nxt = S_DONE;
              end else begin
                op_nxt = OP_SQR;
                go_nxt = 1'b1;
              end
            end
            OP_SQR: begin
              base_nxt = mm_res;
              exp_nxt  = exp_r >> 1;
              op_nxt   = exp_r[1] ? OP_MUL : OP_SQR;
              go_nxt   = 1'b1;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          result_nxt    = (req_r == REQ_DECRYPT) ? VALUE_W'(acc_r[CHAR_W-1:0])
                                                 : VALUE_W'(acc_r);
          last_out_nxt  = last_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_exp_r   <= ENC_EXP_RST;
      dec_exp_r   <= DEC_EXP_RST;
      modulus_r   <= MODULUS_RST;
      state_r     <= S_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      enc_exp_r   <= enc_exp_nxt;
      dec_exp_r   <= dec_exp_nxt;
      modulus_r   <= modulus_nxt;
      state_r     <= state_nxt;
      go_r        <= go_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    req_r      <= req_nxt;
    last_r     <= last_nxt;
    exp_r      <= exp_nxt;
    val_r      <= val_nxt;
    base_r     <= base_nxt;
    acc_r      <= acc_nxt;
    result_r   <= result_nxt;
    last_out_r <= last_out_nxt;
  end

  rsa_modmul #(
    .W (CW)
  ) u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (go_r),
    .a     (mm_a),
    .b     (mm_b),
    .m     (mod_m),
    .done  (mm_done),
    .res   (mm_res)
  );

  assign in_stall     = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_result   = result_r;
  assign out_last_out = last_out_r;

  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    mm_done |-> (state_r == S_RUN))
    else $error("multiplier finished outside of a run");

  a_res_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    mm_done |-> (mm_res < mod_m))
    else $error("multiplier result not reduced by the modulus");

  a_exp_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (exp_r != '0))
    else $error("exponent exhausted while still running");

endmodule

[bench/rsa_char_codec_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_char_codec_tb
// Self-checking bench for the RSA character codec. Directed items cover
// zero exponents, unit and zero moduli, full-width values and the register
// map. Random items follow over many key settings: mostly encrypt/decrypt
// round trips of short strings under real key pairs, plus noise under
// random settings. Random idling on both channels, one long output hold.
// ----------------------------------------------------------------------------
module rsa_char_codec_tb
  import rsa_pkg::*;
();

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int LONG_HOLD = 3000;
  localparam int TAIL_CYCLES = 700;
  localparam int RANDOM_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 75;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [VALUE_W-1:0] CHAR_MASK = 16'h00FF;

  typedef struct packed {
    logic               req;
    logic [VALUE_W-1:0] value;
    logic               last;
  } char_request_t;

  typedef struct packed {
    logic [VALUE_W-1:0] code;
    logic               last;
  } code_result_t;

  typedef struct {
    logic [VALUE_W-1:0] n;
    logic [EXP_W-1:0]   e;
    logic [EXP_W-1:0]   d;
  } rsa_key_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_req_type = REQ_ENCRYPT;
  logic [VALUE_W-1:0]    in_value = '0;
  logic                  in_last_in = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [VALUE_W-1:0]    out_result;
  logic                  out_last_out;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic [EXP_W-1:0]   enc_exp_cfg = ENC_EXP_RST;
  logic [EXP_W-1:0]   dec_exp_cfg = DEC_EXP_RST;
  logic [VALUE_W-1:0] modulus_cfg = MODULUS_RST;

  char_request_t char_requests[$];
  code_result_t  expected_codes[$];
  char_request_t offered;
  code_result_t  want;
  rsa_key_t      key_pairs[5];

  int  idle_odds = 8;
  int  send_gap = 0;
  int  stall_left = 0;
  bit  long_hold_req = 1'b0;
  bit  long_hold_done = 1'b0;
  int  fail_count = 0;
  int  enc_accepted = 0;
  int  dec_accepted = 0;
  int  settings_run = 0;
  int  cycle_count = 0;

  rsa_char_codec uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_value    (in_value),
    .in_last_in  (in_last_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_result  (out_result),
    .out_last_out(out_last_out),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #6 clk = ~clk;

  function automatic code_result_t predict_code(char_request_t item);
    longint unsigned acc;
    longint unsigned base;
    longint unsigned m;
    longint unsigned e;
    int              steps;
    code_result_t    r;
    m = 64'(modulus_cfg);
    e = 64'((item.req == REQ_ENCRYPT) ? enc_exp_cfg : dec_exp_cfg);
    acc = 64'd1;
    if (m == 0) begin
      acc = 64'd0;
    end else begin
      base = 64'(item.value) % m;
      steps = 0;
      while (e != 0 && steps < EXP_W) begin
        if (e[0]) acc = (acc * base) % m;
        base = (base * base) % m;
        e = e >> 1;
        steps++;
      end
    end
    r.code = acc[VALUE_W-1:0];
    if (item.req == REQ_DECRYPT) r.code = r.code & CHAR_MASK;
    r.last = item.last;
    return r;
  endfunction

  // Input side: offers queued items, with random gaps between them.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_codes.push_back(predict_code(offered));
        if (offered.req == REQ_ENCRYPT) enc_accepted++;
        else dec_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap--;
        end else if (char_requests.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
          send_gap = $urandom_range(0, 17);
          in_valid <= 1'b0;
        end else begin
          offered = char_requests.pop_front();
          in_req_type <= offered.req;
          in_value <= offered.value;
          in_last_in <= offered.last;
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Output side: random stall bursts, plus one long hold on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (long_hold_req && !long_hold_done) begin
        stall_left = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        stall_left = $urandom_range(0, 17);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_codes.size() == 0) begin
        $display("%0t: unexpected item: result %h last %b", $time, out_result,
                 out_last_out);
        fail_count++;
      end else begin
        want = expected_codes.pop_front();
        if (out_result !== want.code) begin
          $display("%0t: result mismatch: expected %h, actual %h", $time, want.code,
                   out_result);
          fail_count++;
        end
        if (out_last_out !== want.last) begin
          $display("%0t: last_out mismatch: expected %b, actual %b", $time, want.last,
                   out_last_out);
          fail_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d items outstanding", cycle_count,
             expected_codes.size());
    $display("TEST FAILED");
    $finish;
  end

  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx,
                           input logic [APB_DATA_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'({idx, 2'b00});
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ENC_EXP: enc_exp_cfg = data[EXP_W-1:0];
      REG_DEC_EXP: dec_exp_cfg = data[EXP_W-1:0];
      REG_MODULUS: modulus_cfg = data[VALUE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic cfg_read_check(input logic [REG_IDX_W-1:0] idx,
                                input logic [VALUE_W-1:0] want_val);
    logic [APB_DATA_W-1:0] got;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= APB_ADDR_W'({idx, 2'b00});
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    got = prdata;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (got[VALUE_W-1:0] !== want_val) begin
      $display("%0t: register %0d readback mismatch: expected %h, actual %h", $time, idx,
               want_val, got[VALUE_W-1:0]);
      fail_count++;
    end
    @(negedge clk);
  endtask

  task automatic check_registers();
    cfg_read_check(REG_ENC_EXP, enc_exp_cfg);
    cfg_read_check(REG_DEC_EXP, dec_exp_cfg);
    cfg_read_check(REG_MODULUS, modulus_cfg);
  endtask

  task automatic set_key(input logic [EXP_W-1:0] e, input logic [EXP_W-1:0] d,
                         input logic [VALUE_W-1:0] n);
    cfg_write(REG_ENC_EXP, APB_DATA_W'(e));
    cfg_write(REG_DEC_EXP, APB_DATA_W'(d));
    cfg_write(REG_MODULUS, APB_DATA_W'(n));
    settings_run++;
  endtask

  task automatic push_item(input logic req, input logic [VALUE_W-1:0] value, input logic last);
    char_request_t item;
    item.req = req;
    item.value = value;
    item.last = last;
    char_requests.push_back(item);
  endtask

  // Encrypts a short string, then decrypts its ciphertext codes.
  task automatic push_round_trip(input int len);
    char_request_t      item;
    code_result_t       enc_res;
    logic [VALUE_W-1:0] cipher[$];
    for (int i = 0; i < len; i++) begin
      item.req = REQ_ENCRYPT;
      item.value = VALUE_W'($urandom_range(0, 255));
      item.last = (i == len - 1);
      char_requests.push_back(item);
      enc_res = predict_code(item);
      cipher.push_back(enc_res.code);
    end
    for (int i = 0; i < len; i++) push_item(REQ_DECRYPT, cipher[i], i == len - 1);
  endtask

  task automatic wait_for_drain();
    do @(negedge clk);
    while (char_requests.size() != 0 || in_valid || expected_codes.size() != 0);
  endtask

  initial begin
    char_request_t probe;
    code_result_t  probe_code;
    rsa_key_t      k;
    bit            use_key;
    int            queued;
    int            len;

    key_pairs[0] = '{n: 16'd3233, e: 16'd17, d: 16'd2753};
    key_pairs[1] = '{n: 16'd33, e: 16'd3, d: 16'd7};
    key_pairs[2] = '{n: 16'd55, e: 16'd3, d: 16'd27};
    key_pairs[3] = '{n: 16'd143, e: 16'd7, d: 16'd103};
    key_pairs[4] = '{n: 16'd64507, e: 16'd3, d: 16'd42667};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset key, full range of values and both request types.
    check_registers();
    settings_run++;
    probe.req = REQ_ENCRYPT;
    probe.value = 16'd65;
    probe.last = 1'b0;
    probe_code = predict_code(probe);
    push_item(REQ_ENCRYPT, 16'd0, 1'b0);
    push_item(REQ_ENCRYPT, 16'd65, 1'b0);
    push_item(REQ_ENCRYPT, 16'd255, 1'b0);
    push_item(REQ_ENCRYPT, 16'hFFFF, 1'b1);
    push_item(REQ_ENCRYPT, 16'd3233, 1'b0);
    push_item(REQ_DECRYPT, 16'd0, 1'b0);
    push_item(REQ_DECRYPT, probe_code.code, 1'b0);
    push_item(REQ_DECRYPT, 16'd3232, 1'b0);
    push_item(REQ_DECRYPT, 16'hFFFF, 1'b1);
    wait_for_drain();

    // Zero exponents give one, even with a unit modulus.
    set_key(16'd0, 16'd0, 16'd1);
    push_item(REQ_ENCRYPT, 16'd5, 1'b0);
    push_item(REQ_DECRYPT, 16'hFFFF, 1'b1);
    push_item(REQ_ENCRYPT, 16'd0, 1'b0);
    wait_for_drain();

    // A zero modulus gives zero; a write past the last register is ignored.
    set_key(16'd17, 16'hFFFF, 16'd0);
    cfg_write(REG_UNUSED, 32'hFFFF_FFFF);
    check_registers();
    push_item(REQ_ENCRYPT, 16'd100, 1'b0);
    push_item(REQ_DECRYPT, 16'd200, 1'b1);
    wait_for_drain();

    set_key(16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_item(REQ_ENCRYPT, 16'hFFFE, 1'b0);
    push_item(REQ_DECRYPT, 16'hFFFF, 1'b0);
    push_item(REQ_ENCRYPT, 16'd2, 1'b0);
    push_item(REQ_DECRYPT, 16'd1, 1'b1);
    wait_for_drain();

    // Values above the modulus are reduced before the first step.
    set_key(16'd1, 16'd1, 16'd65521);
    push_item(REQ_ENCRYPT, 16'hFFFF, 1'b0);
    push_item(REQ_DECRYPT, 16'd300, 1'b1);
    wait_for_drain();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      use_key = 1'($urandom_range(0, 1));
      if (use_key) begin
        k = key_pairs[$urandom_range(0, 4)];
        set_key(k.e, k.d, k.n);
      end else begin
        cfg_write(REG_ENC_EXP, $urandom);
        cfg_write(REG_DEC_EXP, $urandom);
        if ($urandom_range(0, 3) == 0) begin
          cfg_write(REG_MODULUS, APB_DATA_W'($urandom_range(1, 255)));
        end else begin
          cfg_write(REG_MODULUS, $urandom);
        end
        settings_run++;
      end
      check_registers();
      if (phase == RANDOM_PHASES - 1) idle_odds = 0;
      else if ($urandom_range(0, 3) == 0) idle_odds = 0;
      else idle_odds = $urandom_range(4, 12);
      if (phase == 3) long_hold_req = 1'b1;
      queued = 0;
      while (queued < ITEMS_PER_PHASE) begin
        if (use_key && $urandom_range(0, 3) != 0) begin
          len = $urandom_range(1, 10);
          push_round_trip(len);
          queued += 2 * len;
        end else begin
          push_item(1'($urandom_range(0, 1)), VALUE_W'($urandom),
                    1'($urandom_range(0, 1)));
          queued++;
        end
      end
      wait_for_drain();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (expected_codes.size() != 0) begin
      $display("%0t: %0d expected items never arrived", $time, expected_codes.size());
      fail_count++;
    end
    $display("Ran %0d encrypt and %0d decrypt items under %0d key settings,",
             enc_accepted, dec_accepted, settings_run);
    $display("with round-trip strings, zero and unit moduli, and a long output hold.");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
